// File: rtl/msae_pkg.sv
// Shared constants, types and microcode program of the servo angle engine.
package msae_pkg;

	localparam int NUM_FEATURES   = 6;
	localparam int NUM_HIDDEN     = 4;
	localparam int NUM_OUTPUTS    = 8;
	localparam int FEATURE_FIELDS = 6;
	localparam int ANGLE_FIELDS   = 8;

	localparam int L1_COUNT      = NUM_HIDDEN * NUM_FEATURES;
	localparam int L2_COUNT      = NUM_OUTPUTS * NUM_HIDDEN;
	localparam int STORE_DEPTH   = L1_COUNT + L2_COUNT;
	localparam int DEFAULT_COUNT = 56;

	localparam int INDEX_W  = 6;
	localparam int WEIGHT_W = 16;
	localparam int FEAT_W   = 32;
	localparam int ANGLE_W  = 8;
	localparam int PROD_W   = WEIGHT_W + FEAT_W;

	localparam int ADDR_W    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int DFLT_IW   = $clog2(DEFAULT_COUNT);
	localparam int FEAT_IW   = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
	localparam int HID_IW    = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;
	localparam int OUT_IW    = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
	localparam int ANG_IW    = $clog2(ANGLE_FIELDS);
	localparam int SRC_W     = (FEAT_IW > HID_IW) ? FEAT_IW : HID_IW;
	localparam int DST_W     = (HID_IW > OUT_IW) ? HID_IW : OUT_IW;
	localparam int SUM_TERMS = (NUM_FEATURES > NUM_HIDDEN) ? NUM_FEATURES : NUM_HIDDEN;
	localparam int ACC_W     = PROD_W + $clog2(SUM_TERMS) + 1;
	localparam int T_W       = ACC_W + 6;

	localparam int HID_SHIFT = 14;
	localparam int OUT_SHIFT = 30;
	localparam int CENTER_DEG = 90;
	localparam int MAX_DEG    = 180;
	localparam longint CENTER_Q30 = longint'(CENTER_DEG) << OUT_SHIFT;

	localparam logic ITEM_WRITE = 1'b0;
	localparam logic ITEM_RUN   = 1'b1;

	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_NOP  = 3'd0;
	localparam logic [OP_W-1:0] OP_MAC  = 3'd1;
	localparam logic [OP_W-1:0] OP_HID  = 3'd2;
	localparam logic [OP_W-1:0] OP_OUT  = 3'd3;
	localparam logic [OP_W-1:0] OP_EMIT = 3'd4;

	typedef logic [INDEX_W-1:0] index_t;
	typedef logic signed [WEIGHT_W-1:0] weight_t;
	typedef logic signed [FEAT_W-1:0] feat_t;
	typedef logic [ANGLE_W-1:0] angle_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic              layer;
		logic [ADDR_W-1:0] waddr;
		logic [SRC_W-1:0]  src;
		logic [DST_W-1:0]  dst;
	} ucode_t;

	localparam int CW_W     = $bits(ucode_t);
	localparam int PROG_LEN = NUM_HIDDEN * (NUM_FEATURES + 1) + 1
		+ NUM_OUTPUTS * (NUM_HIDDEN + 1) + 4;
	localparam int PC_W     = $clog2(PROG_LEN);

	typedef logic [PROG_LEN-1:0][CW_W-1:0] prog_t;

	function automatic prog_t build_prog();
		prog_t  p;
		ucode_t w;
		int     n;
		p = '0;
		n = 0;
		for (int h = 0; h < NUM_HIDDEN; h++) begin
			for (int f = 0; f < NUM_FEATURES; f++) begin
				w = '0;
				w.op = OP_MAC;
				w.layer = 1'b0;
				w.waddr = ADDR_W'(h * NUM_FEATURES + f);
				w.src = SRC_W'(f);
				p[n] = w;
				n++;
			end
			w = '0;
			w.op = OP_HID;
			w.dst = DST_W'(h);
			p[n] = w;
			n++;
		end
		n++;
		for (int o = 0; o < NUM_OUTPUTS; o++) begin
			for (int h = 0; h < NUM_HIDDEN; h++) begin
				w = '0;
				w.op = OP_MAC;
				w.layer = 1'b1;
				w.waddr = ADDR_W'(L1_COUNT + o * NUM_HIDDEN + h);
				w.src = SRC_W'(h);
				p[n] = w;
				n++;
			end
			w = '0;
			w.op = OP_OUT;
			w.dst = DST_W'(o);
			p[n] = w;
			n++;
		end
		n = n + 3;
		w = '0;
		w.op = OP_EMIT;
		p[n] = w;
		return p;
	endfunction

	localparam prog_t PROG = build_prog();

	localparam weight_t DEFAULT_W [DEFAULT_COUNT] = '{
		16'sd8192, -16'sd3277, 16'sd4915, 16'sd1638, -16'sd6554, 16'sd3277,
		-16'sd4915, 16'sd9830, -16'sd1638, 16'sd3277, 16'sd8192, -16'sd3277,
		16'sd3277, 16'sd1638, -16'sd8192, 16'sd6554, -16'sd4915, 16'sd9830,
		-16'sd6554, 16'sd4915, 16'sd3277, -16'sd1638, 16'sd9830, 16'sd1638,
		16'sd4915, -16'sd3277, 16'sd8192, 16'sd1638,
		-16'sd1638, 16'sd6554, -16'sd4915, 16'sd9830,
		16'sd3277, 16'sd4915, -16'sd6554, 16'sd8192,
		-16'sd8192, 16'sd3277, 16'sd1638, -16'sd4915,
		16'sd9830, -16'sd1638, 16'sd3277, 16'sd6554,
		-16'sd3277, 16'sd8192, -16'sd9830, 16'sd4915,
		16'sd1638, -16'sd6554, 16'sd4915, 16'sd3277,
		16'sd6554, 16'sd1638, -16'sd3277, 16'sd8192
	};

endpackage

// File: rtl/mlp_servo_angle_engine.sv
// Top level of the servo angle engine: microcoded two-layer perceptron.
// A write item (op 0) stores one Q2.14 weight and is taken without raising item_stall; it
// gives no result. A run item (op 1) starts a microcode program of
// NUM_HIDDEN*(NUM_FEATURES+1) + 1 + NUM_OUTPUTS*(NUM_HIDDEN+1) + 4 steps, 73 with the
// default sizes, one step per cycle unless held at the emit step: one multiply-accumulate
// per step on a single shared 16x32 multiplier, plus one step per hidden unit and per
// output to finish it. The result transfer is offered once the emit step has run, and
// item_stall drops in that same cycle; no item is taken while a pass runs. The result
// sits in an output register, so a new item can be taken while it waits; a following
// pass holds at its last step until that register is free. The weight store powers up
// holding the default network.
module mlp_servo_angle_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  logic             op,
	input  msae_pkg::index_t weight_index,
	input  msae_pkg::weight_t weight_value,
	input  msae_pkg::feat_t  feature_0,
	input  msae_pkg::feat_t  feature_1,
	input  msae_pkg::feat_t  feature_2,
	input  msae_pkg::feat_t  feature_3,
	input  msae_pkg::feat_t  feature_4,
	input  msae_pkg::feat_t  feature_5,
	output logic             result_valid,
	input  logic             result_stall,
	output msae_pkg::angle_t angle_0,
	output msae_pkg::angle_t angle_1,
	output msae_pkg::angle_t angle_2,
	output msae_pkg::angle_t angle_3,
	output msae_pkg::angle_t angle_4,
	output msae_pkg::angle_t angle_5,
	output msae_pkg::angle_t angle_6,
	output msae_pkg::angle_t angle_7
);
	import msae_pkg::*;

	logic              busy_q;
	logic [PC_W-1:0]   pc_q;
	ucode_t            cw;
	ucode_t            issue;
	ucode_t            cw_s1;
	ucode_t            cw_s2;
	ucode_t            cw_s3;
	logic              accept;
	logic              emit;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;

	weight_t           wmem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] wvld_q;
	weight_t           wdat_s1;
	weight_t           wdflt_s1;
	logic              wvld_s1;
	weight_t           weight_s1;
	feat_t             opnd_s1;

	feat_t             feat_in [FEATURE_FIELDS];
	feat_t             feat_q [NUM_FEATURES];
	feat_t             hid_q [NUM_HIDDEN];
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [T_W-1:0]    t_s3;
	logic [T_W-OUT_SHIFT-1:0] deg_s3;
	angle_t            angle_q [ANGLE_FIELDS];
	angle_t            res_q [ANGLE_FIELDS];
	logic              result_valid_q;

	function automatic feat_t relu_sat(input logic signed [ACC_W-1:0] a);
		logic [ACC_W-HID_SHIFT-1:0] sh;
		sh = a[ACC_W-1:HID_SHIFT];
		if (a[ACC_W-1] || a == '0) begin
			return '0;
		end else if (|sh[ACC_W-HID_SHIFT-1:FEAT_W-1]) begin
			return {1'b0, {(FEAT_W-1){1'b1}}};
		end else begin
			return sh[FEAT_W-1:0];
		end
	endfunction

	assign feat_in[0] = feature_0;
	assign feat_in[1] = feature_1;
	assign feat_in[2] = feature_2;
	assign feat_in[3] = feature_3;
	assign feat_in[4] = feature_4;
	assign feat_in[5] = feature_5;

	assign item_stall   = busy_q;
	assign accept       = item_valid && !busy_q;
	assign cw           = PROG[pc_q];
	assign emit         = busy_q && cw.op == OP_EMIT && !(result_valid_q && result_stall);
	assign issue        = busy_q ? cw : '0;
	assign wr_en        = accept && op == ITEM_WRITE && 32'(weight_index) < 32'(STORE_DEPTH);
	assign wr_addr      = ADDR_W'(weight_index);
	assign result_valid = result_valid_q;

	// sequencer: advance one step per cycle, hold on the emit step while the output is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (!busy_q) begin
			if (accept && op == ITEM_RUN) begin
				busy_q <= 1'b1;
				pc_q   <= '0;
			end
		end else if (cw.op == OP_EMIT) begin
			if (emit) begin
				busy_q <= 1'b0;
				pc_q   <= '0;
			end
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_s1 <= '0;
			cw_s2 <= '0;
			cw_s3 <= '0;
		end else begin
			cw_s1 <= issue;
			cw_s2 <= cw_s1;
			cw_s3 <= cw_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && op == ITEM_RUN) begin
			for (int i = 0; i < NUM_FEATURES; i++) begin
				feat_q[i] <= (i < FEATURE_FIELDS) ? feat_in[i] : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			wmem[wr_addr] <= weight_value;
		end
		wdat_s1 <= wmem[cw.waddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvld_q <= '0;
		end else if (wr_en) begin
			wvld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		wvld_s1  <= wvld_q[cw.waddr];
		wdflt_s1 <= (32'(cw.waddr) < 32'(DEFAULT_COUNT)) ? DEFAULT_W[DFLT_IW'(cw.waddr)] : '0;
	end

	assign weight_s1 = wvld_s1 ? wdat_s1 : wdflt_s1;
	assign opnd_s1   = cw_s1.layer ? hid_q[cw_s1.src[HID_IW-1:0]]
		: feat_q[cw_s1.src[FEAT_IW-1:0]];

	always_ff @(posedge clk) begin
		prod_s2 <= weight_s1 * opnd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			case (cw_s2.op)
				OP_MAC: acc_q <= acc_q + ACC_W'(prod_s2);
				OP_HID, OP_OUT: acc_q <= '0;
				default: acc_q <= acc_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cw_s2.op == OP_HID) begin
			hid_q[cw_s2.dst[HID_IW-1:0]] <= relu_sat(acc_q);
		end
		if (cw_s2.op == OP_OUT) begin
			t_s3 <= (T_W'(acc_q) <<< 5) - (T_W'(acc_q) <<< 1) + T_W'(CENTER_Q30);
		end
	end

	assign deg_s3 = t_s3[T_W-1:OUT_SHIFT];

	always_ff @(posedge clk) begin
		if (cw_s3.op == OP_OUT && 32'(cw_s3.dst) < 32'(ANGLE_FIELDS)) begin
			if (t_s3[T_W-1]) begin
				angle_q[ANG_IW'(cw_s3.dst)] <= '0;
			end else if (deg_s3 > (T_W-OUT_SHIFT)'(MAX_DEG)) begin
				angle_q[ANG_IW'(cw_s3.dst)] <= ANGLE_W'(MAX_DEG);
			end else begin
				angle_q[ANG_IW'(cw_s3.dst)] <= deg_s3[ANGLE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			for (int i = 0; i < ANGLE_FIELDS; i++) begin
				res_q[i] <= (i < NUM_OUTPUTS) ? angle_q[i] : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign angle_0 = res_q[0];
	assign angle_1 = res_q[1];
	assign angle_2 = res_q[2];
	assign angle_3 = res_q[3];
	assign angle_4 = res_q[4];
	assign angle_5 = res_q[5];
	assign angle_6 = res_q[6];
	assign angle_7 = res_q[7];

endmodule

// File: rtl/msae_checker.sv
// Port-level checks of the servo angle engine and their binding to the top level.
module msae_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input logic             op,
	input logic             result_valid,
	input logic             result_stall,
	input msae_pkg::angle_t angle_0,
	input msae_pkg::angle_t angle_1,
	input msae_pkg::angle_t angle_2,
	input msae_pkg::angle_t angle_3,
	input msae_pkg::angle_t angle_4,
	input msae_pkg::angle_t angle_5,
	input msae_pkg::angle_t angle_6,
	input msae_pkg::angle_t angle_7
);
	import msae_pkg::*;

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> angle_0 <= 8'd180 && angle_1 <= 8'd180 && angle_2 <= 8'd180
			&& angle_3 <= 8'd180 && angle_4 <= 8'd180 && angle_5 <= 8'd180
			&& angle_6 <= 8'd180 && angle_7 <= 8'd180)
		else $error("angle out of range");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && op == ITEM_RUN |=> item_stall)
		else $error("run transfer did not start a pass");

	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && op == ITEM_WRITE |=> !item_stall)
		else $error("weight write held the input");

	a_result_from_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result without a pass");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("stalled result dropped");

endmodule

bind mlp_servo_angle_engine msae_checker u_msae_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for the servo angle engine: directed table, then random writes and passes.
module testbench;
	import msae_pkg::*;

	localparam int RANDOM_ITEMS  = 2000;
	localparam int HOLD_AT       = 600;
	localparam int HOLD_ITEMS    = 12;
	localparam int HOLD_CYCLES   = 500;
	localparam int DRAIN_AT      = 1200;
	localparam int QUIET_AT      = RANDOM_ITEMS - 200;
	localparam int SETTLE_CYCLES = 100;
	localparam int DIRECTED_ROWS = 22;

	localparam logic [31:0] F_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] F_MIN = 32'h8000_0000;
	localparam logic [31:0] F_ONE = 32'h0001_0000;

	typedef logic [ANGLE_FIELDS-1:0][ANGLE_W-1:0] angles_t;
	typedef logic [FEATURE_FIELDS-1:0][FEAT_W-1:0] feats_t;

	typedef struct packed {
		logic    op;
		index_t  idx;
		weight_t wval;
		feats_t  feat;
		logic    check;
		angles_t angles;
	} stim_row_t;

	localparam weight_t POWER_ON_WEIGHTS [DEFAULT_COUNT] = '{
		8192, -3277, 4915, 1638, -6554, 3277,
		-4915, 9830, -1638, 3277, 8192, -3277,
		3277, 1638, -8192, 6554, -4915, 9830,
		-6554, 4915, 3277, -1638, 9830, 1638,
		4915, -3277, 8192, 1638,
		-1638, 6554, -4915, 9830,
		3277, 4915, -6554, 8192,
		-8192, 3277, 1638, -4915,
		9830, -1638, 3277, 6554,
		-3277, 8192, -9830, 4915,
		1638, -6554, 4915, 3277,
		6554, 1638, -3277, 8192
	};

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	logic    op = ITEM_WRITE;
	index_t  weight_index = '0;
	weight_t weight_value = '0;
	feat_t   feature_0 = '0;
	feat_t   feature_1 = '0;
	feat_t   feature_2 = '0;
	feat_t   feature_3 = '0;
	feat_t   feature_4 = '0;
	feat_t   feature_5 = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	angle_t  angle_0;
	angle_t  angle_1;
	angle_t  angle_2;
	angle_t  angle_3;
	angle_t  angle_4;
	angle_t  angle_5;
	angle_t  angle_6;
	angle_t  angle_7;

	weight_t   weight_mem [STORE_DEPTH];
	angles_t   expected_angles [$];
	stim_row_t directed [DIRECTED_ROWS];
	int        angle_errors = 0;
	logic      hold_request = 1'b0;
	logic      quiet = 1'b0;

	mlp_servo_angle_engine dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic angles_t servo_angles(input feats_t feats);
		longint  acc;
		longint  t;
		longint  hid [NUM_HIDDEN];
		angles_t deg;
		deg = '0;
		for (int h = 0; h < NUM_HIDDEN; h++) begin
			acc = 0;
			for (int f = 0; f < NUM_FEATURES; f++)
				acc += longint'(weight_mem[h * NUM_FEATURES + f]) * longint'(signed'(feats[f]));
			if (acc <= 0) begin
				hid[h] = 0;
			end else begin
				hid[h] = acc >>> 14;
				if (hid[h] > 64'sh7FFF_FFFF)
					hid[h] = 64'sh7FFF_FFFF;
			end
		end
		for (int o = 0; o < NUM_OUTPUTS && o < ANGLE_FIELDS; o++) begin
			acc = 0;
			for (int h = 0; h < NUM_HIDDEN; h++)
				acc += longint'(weight_mem[L1_COUNT + o * NUM_HIDDEN + h]) * hid[h];
			t = (longint'(90) <<< 30) + 30 * acc;
			if (t < 0)
				deg[o] = 8'd0;
			else if ((t >>> 30) > 180)
				deg[o] = 8'd180;
			else
				deg[o] = angle_t'(t >>> 30);
		end
		return deg;
	endfunction

	function automatic stim_row_t mk(input logic kind, input int idx, input int wval,
			input feats_t feats, input bit check, input int deg);
		stim_row_t r;
		r.op = kind;
		r.idx = index_t'(idx);
		r.wval = weight_t'(wval);
		r.feat = feats;
		r.check = check;
		r.angles = {ANGLE_FIELDS{angle_t'(deg)}};
		return r;
	endfunction

	function automatic logic [31:0] rand_feature();
		logic [31:0] raw;
		raw = $urandom;
		if ($urandom_range(0, 3) == 0)
			return raw;
		return 32'($signed(raw) >>> $urandom_range(0, 31));
	endfunction

	function automatic weight_t rand_weight();
		logic [15:0] raw;
		raw = 16'($urandom);
		if ($urandom_range(0, 3) == 0)
			return raw;
		return weight_t'($signed(raw) >>> $urandom_range(0, 15));
	endfunction

	function automatic stim_row_t random_row(input bit force_run);
		stim_row_t r;
		r.op = (force_run || $urandom_range(0, 99) < 65) ? ITEM_RUN : ITEM_WRITE;
		r.idx = index_t'($urandom_range(0, 63));
		r.wval = rand_weight();
		for (int f = 0; f < FEATURE_FIELDS; f++)
			r.feat[f] = rand_feature();
		r.check = 1'b0;
		r.angles = '0;
		return r;
	endfunction

	function automatic int idle_gap();
		if ($urandom_range(0, 2) != 0)
			return 0;
		return $urandom_range(1, 12);
	endfunction

	task automatic wait_drained();
		do @(negedge clk); while (expected_angles.size() != 0);
		@(posedge clk);
	endtask

	task automatic offer_item(input stim_row_t r, input bit drain_after, input int gap);
		item_valid <= 1'b1;
		op <= r.op;
		weight_index <= r.idx;
		weight_value <= r.wval;
		feature_0 <= r.feat[0];
		feature_1 <= r.feat[1];
		feature_2 <= r.feat[2];
		feature_3 <= r.feat[3];
		feature_4 <= r.feat[4];
		feature_5 <= r.feat[5];
		do @(posedge clk); while (item_stall);
		if (r.op == ITEM_WRITE) begin
			if (r.idx < STORE_DEPTH)
				weight_mem[r.idx] = r.wval;
		end else begin
			expected_angles.push_back(r.check ? r.angles : servo_angles(r.feat));
		end
		if (drain_after || gap > 0) begin
			item_valid <= 1'b0;
			if (drain_after)
				wait_drained();
			else
				repeat (gap) @(posedge clk);
		end
	endtask

	initial begin : stimulus
		stim_row_t r;
		bit        in_hold;
		for (int i = 0; i < STORE_DEPTH; i++)
			weight_mem[i] = (i < DEFAULT_COUNT) ? POWER_ON_WEIGHTS[i] : weight_t'(0);
		directed = '{
			mk(ITEM_RUN,    0,      0, '0,                1'b1, 90),
			mk(ITEM_RUN,    0,      0, {6{F_MAX}},        1'b0, 0),
			mk(ITEM_RUN,    0,      0, {6{F_MIN}},        1'b0, 0),
			mk(ITEM_RUN,    0,      0, {3{F_MAX, F_MIN}}, 1'b0, 0),
			mk(ITEM_RUN,   63, -32768, {6{F_ONE}},        1'b0, 0),
			mk(ITEM_WRITE, 56,  32767, {6{F_MAX}},        1'b0, 0),
			mk(ITEM_WRITE, 63, -32768, {6{F_MIN}},        1'b0, 0),
			mk(ITEM_RUN,    0,      0, '0,                1'b1, 90),
			mk(ITEM_WRITE,  0,  32767, '0,                1'b0, 0),
			mk(ITEM_RUN,    0,      0, {160'd0, F_MAX},   1'b0, 0),
			mk(ITEM_WRITE, 24, -32768, '0,                1'b0, 0),
			mk(ITEM_RUN,    0,      0, {160'd0, F_MAX},   1'b0, 0),
			mk(ITEM_WRITE, 24,  32767, '0,                1'b0, 0),
			mk(ITEM_RUN,    0,      0, {160'd0, F_MAX},   1'b0, 0),
			mk(ITEM_WRITE, 55, -32768, '0,                1'b0, 0),
			mk(ITEM_WRITE, 23,  32767, '0,                1'b0, 0),
			mk(ITEM_RUN,    0,      0, {6{F_MAX}},        1'b0, 0),
			mk(ITEM_RUN,    0,      0, {6{32'hFFFF_FFFF}}, 1'b0, 0),
			mk(ITEM_RUN,    0,      0, {6{32'h0000_0001}}, 1'b0, 0),
			mk(ITEM_RUN,    0,      0, {32'h1234_5678, 32'hEDCB_A988, F_ONE,
				32'hFFFE_0000, 32'h0003_8000, 32'hFFFF_8000}, 1'b0, 0),
			mk(ITEM_WRITE,  0,      0, '0,                1'b0, 0),
			mk(ITEM_RUN,    0,      0, '0,                1'b1, 90)
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			offer_item(directed[i], 1'b0, idle_gap());
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			in_hold = (n >= HOLD_AT && n < HOLD_AT + HOLD_ITEMS);
			if (n == HOLD_AT)
				hold_request <= 1'b1;
			if (n == QUIET_AT)
				quiet <= 1'b1;
			r = random_row(in_hold);
			offer_item(r, n == DRAIN_AT, (in_hold || n >= QUIET_AT) ? 0 : idle_gap());
		end
		item_valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (angle_errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin : result_backpressure
		bit held;
		held = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request && !held) begin
				held = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (quiet || $urandom_range(0, 2) != 0) begin
				result_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : result_check
		angles_t want;
		angles_t got;
		if (result_valid && !result_stall) begin
			got = {angle_7, angle_6, angle_5, angle_4, angle_3, angle_2, angle_1, angle_0};
			if (expected_angles.size() == 0) begin
				$display("%0t: result transfer with no pass pending, expected none, actual %h",
					$time, got);
				angle_errors++;
			end else begin
				want = expected_angles.pop_front();
				for (int i = 0; i < ANGLE_FIELDS; i++) begin
					if (got[i] !== want[i]) begin
						$display("%0t: angle_%0d expected %0d actual %0d",
							$time, i, want[i], got[i]);
						angle_errors++;
					end
				end
			end
		end
	end

	initial begin : watchdog
		#(8 * 750_000);
		$display("testbench failed");
		$finish;
	end

endmodule
